// File: hw/rtl/fidr_pkg.sv
// ----------------------------------------------------------------------------
// fidr_pkg
// Shared types and constants for the flight ID token recognizer.
// ----------------------------------------------------------------------------
package fidr_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam int unsigned MAX_LETTERS = 3;
  localparam int unsigned MIN_LETTERS = 2;
  localparam int unsigned MAX_DIGITS  = 4;
  localparam int unsigned MIN_DIGITS  = 2;
  localparam int unsigned TOKEN_BYTES = 8;

  localparam logic [7:0] CAPACITY_RESET = 8'd9;

  typedef enum logic [2:0] {
    PH_SKIP    = 3'd0,
    PH_LETTERS = 3'd1,
    PH_DIGITS  = 3'd2,
    PH_LOOK    = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  // one held request from the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] text_byte;
  } item_t;

  // one result
  typedef struct packed {
    logic [3:0]  token_length;
    logic [63:0] token_text;
  } result_t;

endpackage

// File: hw/rtl/fidr_in_stage.sv
// ----------------------------------------------------------------------------
// fidr_in_stage
// Input register: holds one text byte until the scanner consumes it.
// ----------------------------------------------------------------------------
module fidr_in_stage
  import fidr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       advance,
  output item_t      held
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       take;

  assign in_stall = hold_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_byte <= text_byte;
    end
  end

  assign held.valid     = hold_valid;
  assign held.text_byte = hold_byte;

endmodule

// File: hw/rtl/fidr_scanner.sv
// ----------------------------------------------------------------------------
// fidr_scanner
// Token shape matcher: scan state, capacity register and result forming.
// ----------------------------------------------------------------------------
module fidr_scanner
  import fidr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  item_t      held,
  input  logic       out_ready,
  output logic       advance,
  output logic       emit,
  output result_t    result
);

  logic [7:0]  capacity;
  phase_t      phase, phase_next;
  logic [2:0]  runs, runs_next;
  logic [1:0]  letters, letters_next;
  logic [63:0] token_buf, token_buf_next;
  logic [3:0]  count, count_next;
  logic [3:0]  decided, decided_next;

  logic [7:0]  b;
  logic        is_nul, upper, digit;

  assign b      = held.text_byte;
  assign is_nul = (b == CHAR_NUL);
  assign upper  = (b >= CHAR_A) && (b <= CHAR_Z);
  assign digit  = (b >= CHAR_0) && (b <= CHAR_9);

  // nonzero bytes only update state; the end byte also needs the result slot
  assign advance = held.valid && (!is_nul || out_ready);
  assign emit    = advance && is_nul;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write_en) begin
      capacity <= cfg_write_data;
    end
  end

  always_comb begin
    phase_t eff;
    logic   go;
    logic   take;
    phase_next   = phase;
    runs_next    = runs;
    letters_next = letters;
    decided_next = decided;
    eff          = phase;
    go           = 1'b1;
    take         = 1'b0;

    if (eff == PH_SKIP) begin
      if (b == CHAR_SPACE || b == CHAR_TAB) begin
        go = 1'b0;
      end else begin
        eff        = PH_LETTERS;
        phase_next = PH_LETTERS;
      end
    end

    if (go && eff == PH_LETTERS) begin
      if (upper && letters < 2'(MAX_LETTERS)) begin
        take         = 1'b1;
        letters_next = letters + 2'd1;
        go           = 1'b0;
      end else if (letters < 2'(MIN_LETTERS)) begin
        decided_next = 4'd0;
        phase_next   = PH_DONE;
        go           = 1'b0;
      end else begin
        eff        = PH_DIGITS;
        phase_next = PH_DIGITS;
        runs_next  = 3'd0;
      end
    end

    if (go && eff == PH_DIGITS) begin
      if (digit && runs_next < 3'(MAX_DIGITS)) begin
        take      = 1'b1;
        runs_next = runs_next + 3'd1;
      end else if (runs_next < 3'(MIN_DIGITS)) begin
        decided_next = 4'd0;
        phase_next   = PH_DONE;
      end else if (upper) begin
        // trailing letter is provisional until the next byte
        take       = 1'b1;
        phase_next = PH_LOOK;
      end else begin
        decided_next = count;
        phase_next   = PH_DONE;
      end
    end else if (go && eff == PH_LOOK) begin
      decided_next = (!upper && !digit) ? count : count - 4'd1;
      phase_next   = PH_DONE;
    end

    token_buf_next = token_buf;
    count_next     = count;
    if (take && count < 4'(TOKEN_BYTES)) begin
      for (int i = 0; i < TOKEN_BYTES; i++) begin
        if (count[2:0] == 3'(i)) begin
          token_buf_next[i*8 +: 8] = b;
        end
      end
      count_next = count + 4'd1;
    end
  end

  // result formed from the state after scanning the end byte
  always_comb begin
    logic [3:0] len;
    len = (phase_next == PH_DONE) ? decided_next : 4'd0;
    if (capacity == 8'd0) begin
      len = 4'd0;
    end else if ({4'd0, len} >= capacity) begin
      len = 4'(capacity - 8'd1);
    end
    if (len > 4'(TOKEN_BYTES)) begin
      len = 4'(TOKEN_BYTES);
    end
    result.token_length = len;
    for (int i = 0; i < TOKEN_BYTES; i++) begin
      result.token_text[i*8 +: 8] = (4'(i) < len) ? token_buf_next[i*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SKIP;
      runs      <= 3'd0;
      letters   <= 2'd0;
      token_buf <= 64'd0;
      count     <= 4'd0;
      decided   <= 4'd0;
    end else if (advance) begin
      if (is_nul) begin
        phase     <= PH_SKIP;
        runs      <= 3'd0;
        letters   <= 2'd0;
        token_buf <= 64'd0;
        count     <= 4'd0;
        decided   <= 4'd0;
      end else begin
        phase     <= phase_next;
        runs      <= runs_next;
        letters   <= letters_next;
        token_buf <= token_buf_next;
        count     <= count_next;
        decided   <= decided_next;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 4'(TOKEN_BYTES))
    else $error("token count beyond buffer");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    emit |=> (phase == PH_SKIP && count == 4'd0 && token_buf == 64'd0))
    else $error("scan state not cleared after end byte");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (emit && result.token_length == 4'd0) |-> (result.token_text == 64'd0))
    else $error("empty result carries text");

  a_decided_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> (decided <= count))
    else $error("decided length beyond characters taken");

endmodule

// File: hw/rtl/fidr_out_stage.sv
// ----------------------------------------------------------------------------
// fidr_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module fidr_out_stage
  import fidr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        emit,
  input  result_t     result,
  output logic        out_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_length,
  output logic [63:0] token_text
);

  logic    res_valid;
  result_t res;

  assign out_ready = !res_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= result;
    end
  end

  assign out_valid    = res_valid;
  assign token_length = res.token_length;
  assign token_text   = res.token_text;

endmodule

// File: hw/rtl/flight_id_token_recognizer.sv
// ----------------------------------------------------------------------------
// flight_id_token_recognizer
// Finds a flight ID token at the head of a zero-terminated text byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / text_byte) carries one text byte per
//   request; a zero byte ends a text. Leading spaces and tabs are skipped, then
//   the shape is two or three uppercase letters, two to four digits and an
//   optional trailing letter (kept only if the next byte is neither a letter
//   nor a digit).
//   Output channel (out_valid / out_stall / token_length / token_text) carries
//   one request per text, issued for the zero byte only. token_text holds the
//   characters first-in-lowest-byte, unused bytes zero; length 0 means none.
//   cfg_write_en / cfg_write_data set the output capacity (reset 9); the token
//   is cut to capacity minus one characters, capacity zero gives length 0.
//   Write it only while the block is idle.
// Timing:
//   One byte per cycle sustained, except while an end byte awaits the slot.
//   A byte sits in the input register, then is scanned into the scan state or
//   the result register; out_valid rises once the result register is loaded.
//   A stalled output holds its result; the input keeps flowing for nonzero
//   bytes, and only an end byte waits in the input register for the slot.
//   Reset clears the scan, empties both registers and sets capacity to 9.
// ----------------------------------------------------------------------------
module flight_id_token_recognizer
  import fidr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_length,
  output logic [63:0] token_text
);

  item_t   held;
  result_t result;
  logic    advance;
  logic    emit;
  logic    out_ready;

  // input register
  fidr_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .advance   (advance),
    .held      (held)
  );

  // shape matcher and result forming
  fidr_scanner u_scan (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .held           (held),
    .out_ready      (out_ready),
    .advance        (advance),
    .emit           (emit),
    .result         (result)
  );

  // result register
  fidr_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .result       (result),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_length (token_length),
    .token_text   (token_text)
  );

endmodule
